FILE: rtl/dss_pkg.sv
`default_nettype none
package dss_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MASK_W    = 32;
    localparam int WT_W      = 4;
    localparam int MET_W     = 16;
    localparam int WSUM_W    = 8;
    localparam int MSUM_W    = 20;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_PREFER_WEIGHT = 1'b0;
    localparam logic REG_PREFER_METRIC = 1'b1;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic visit;
        logic emit;
        logic finish;
    } dss_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic depth_zero;
        logic fits;
        logic out_free;
        logic emit_last;
    } dss_status_t;

endpackage
`default_nettype wire

FILE: rtl/disjoint_subset_selector_core.sv
// Disjoint subset selector.
// Input channel s_*: one transfer per item (s_item_valid=1) or a bare end
// marker (s_item_valid=0). Up to 16 items are stored, one per cycle while
// s_ready is high; later ones are dropped and reported through m_overflowed.
// A transfer with s_last_item starts an exhaustive depth-first search over
// all subsets with pairwise disjoint masks, ranked by size, then weight sum
// (prefer_weight), then metric sum (low-metric preference), ties to the
// smallest index tuple. The search scans the candidates in index order, visits
// each subset it forms and backtracks at the end of each scan.
// Result channel m_*: selected positions, highest first, each one transfer,
// the last flagged by m_last_result; an empty choice gives one transfer with
// m_none_selected. Results are held in an output register; a stall on m_ready
// holds the emitter, and s_ready stays low from the end item until the last
// result is registered.
// Configuration over APB: register 0 at 0x0, register 1 at 0x4, bit 0 each.
// Reset (aresetn low, synchronous) clears the item count, flags and registers.
`default_nettype none
module disjoint_subset_selector_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [dss_pkg::PADDR_W-1:0]   paddr,
    input  wire [dss_pkg::PDATA_W-1:0]   pwdata,
    output logic [dss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_item_valid,
    input  wire [dss_pkg::MASK_W-1:0]    s_item_mask,
    input  wire [dss_pkg::WT_W-1:0]      s_item_weight,
    input  wire [dss_pkg::MET_W-1:0]     s_item_metric,
    input  wire                          s_last_item,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [dss_pkg::IDX_W-1:0]    m_item_index,
    output logic                         m_none_selected,
    output logic                         m_overflowed,
    output logic                         m_last_result
);

    dss_pkg::dss_cmd_t    cmd;
    dss_pkg::dss_status_t status;
    logic                 prefer_weight_reg;
    logic                 prefer_metric_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefer_weight_reg <= 1'b0;
            prefer_metric_reg <= 1'b0;
        end else if (wr_en) begin
            if (paddr[2] == dss_pkg::REG_PREFER_WEIGHT) begin
                prefer_weight_reg <= pwdata[0];
            end else begin
                prefer_metric_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == dss_pkg::REG_PREFER_WEIGHT) begin
            prdata[0] = prefer_weight_reg;
        end else begin
            prdata[0] = prefer_metric_reg;
        end
    end

    dss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_item (s_last_item),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    dss_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .prefer_weight       (prefer_weight_reg),
        .prefer_low_metric   (prefer_metric_reg),
        .s_item_valid        (s_item_valid),
        .s_item_mask         (s_item_mask),
        .s_item_weight       (s_item_weight),
        .s_item_metric       (s_item_metric),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_item_index        (m_item_index),
        .m_none_selected     (m_none_selected),
        .m_overflowed        (m_overflowed),
        .m_last_result       (m_last_result)
    );

endmodule
`default_nettype wire

FILE: rtl/dss_ctrl.sv
`default_nettype none
module dss_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_last_item,
    output logic                s_ready,
    input  dss_pkg::dss_status_t status,
    output dss_pkg::dss_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_VISIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load = accept;
                if (accept && s_last_item) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_end && status.depth_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.step = 1'b1;
                    if (!status.scan_end && status.fits) begin
                        state_next = ST_VISIT;
                    end
                end
            end
            ST_VISIT: begin
                cmd.visit  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dss_datapath.sv
`default_nettype none
module dss_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  dss_pkg::dss_cmd_t                  cmd,
    output dss_pkg::dss_status_t               status,
    input  wire                                prefer_weight,
    input  wire                                prefer_low_metric,
    input  wire                                s_item_valid,
    input  wire [dss_pkg::MASK_W-1:0]          s_item_mask,
    input  wire [dss_pkg::WT_W-1:0]            s_item_weight,
    input  wire [dss_pkg::MET_W-1:0]           s_item_metric,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [dss_pkg::IDX_W-1:0]          m_item_index,
    output logic                               m_none_selected,
    output logic                               m_overflowed,
    output logic                               m_last_result
);

    localparam int N = dss_pkg::MAX_ITEMS;

    logic [dss_pkg::MASK_W-1:0] mask_mem [N];
    logic [dss_pkg::WT_W-1:0]   wt_mem   [N];
    logic [dss_pkg::MET_W-1:0]  met_mem  [N];

    logic [dss_pkg::MASK_W-1:0] stk_used [N];
    logic [dss_pkg::WSUM_W-1:0] stk_w    [N];
    logic [dss_pkg::MSUM_W-1:0] stk_m    [N];
    logic [dss_pkg::IDX_W-1:0]  stk_j    [N];

    logic [dss_pkg::CNT_W-1:0]  count_reg;
    logic                       drop_reg;
    logic [dss_pkg::CNT_W-1:0]  d_reg;
    logic [dss_pkg::CNT_W-1:0]  j_reg;
    logic [N-1:0]               trial_reg;
    logic [dss_pkg::MASK_W-1:0] used_reg;
    logic [dss_pkg::WSUM_W-1:0] w_reg;
    logic [dss_pkg::MSUM_W-1:0] m_reg;
    logic [N-1:0]               best_reg;
    logic [dss_pkg::CNT_W-1:0]  bsize_reg;
    logic [dss_pkg::WSUM_W-1:0] bw_reg;
    logic [dss_pkg::MSUM_W-1:0] bm_reg;

    logic                       m_valid_reg;
    logic [dss_pkg::IDX_W-1:0]  idx_reg;
    logic                       none_reg;
    logic                       ovf_reg;
    logic                       last_reg;

    logic [dss_pkg::IDX_W-1:0]  jx;
    logic [dss_pkg::IDX_W-1:0]  dx;
    logic [dss_pkg::IDX_W-1:0]  top_idx;
    logic [dss_pkg::IDX_W-1:0]  pop_j;
    logic                       beats;

    assign jx    = j_reg[dss_pkg::IDX_W-1:0];
    assign dx    = d_reg[dss_pkg::IDX_W-1:0];
    assign pop_j = stk_j[dx - 1'b1];

    assign status.scan_end   = (j_reg >= count_reg);
    assign status.depth_zero = (d_reg == '0);
    assign status.fits       = ((used_reg & mask_mem[jx]) == '0);
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.emit_last  = ((best_reg & (best_reg - 1'b1)) == '0);

    always_comb begin
        top_idx = '0;
        for (int k = 0; k < N; k++) begin
            if (best_reg[k]) begin
                top_idx = dss_pkg::IDX_W'(k);
            end
        end
    end

    always_comb begin
        if (d_reg != bsize_reg) begin
            beats = (d_reg > bsize_reg);
        end else if (prefer_weight && (w_reg != bw_reg)) begin
            beats = (w_reg > bw_reg);
        end else if (prefer_low_metric) begin
            beats = (m_reg < bm_reg);
        end else begin
            beats = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && s_item_valid && (count_reg < dss_pkg::CNT_W'(N))) begin
            mask_mem[count_reg[dss_pkg::IDX_W-1:0]] <= s_item_mask;
            wt_mem[count_reg[dss_pkg::IDX_W-1:0]]   <= s_item_weight;
            met_mem[count_reg[dss_pkg::IDX_W-1:0]]  <= s_item_metric;
        end
        if (cmd.step && !status.scan_end && status.fits) begin
            stk_used[dx] <= used_reg;
            stk_w[dx]    <= w_reg;
            stk_m[dx]    <= m_reg;
            stk_j[dx]    <= jx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            d_reg       <= '0;
            j_reg       <= '0;
            trial_reg   <= '0;
            used_reg    <= '0;
            w_reg       <= '0;
            m_reg       <= '0;
            best_reg    <= '0;
            bsize_reg   <= '0;
            bw_reg      <= '0;
            bm_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && s_item_valid) begin
                if (count_reg < dss_pkg::CNT_W'(N)) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.init) begin
                d_reg     <= '0;
                j_reg     <= '0;
                trial_reg <= '0;
                used_reg  <= '0;
                w_reg     <= '0;
                m_reg     <= '0;
                best_reg  <= '0;
                bsize_reg <= '0;
                bw_reg    <= '0;
                bm_reg    <= '0;
            end
            if (cmd.step) begin
                priority if (status.scan_end) begin
                    d_reg     <= d_reg - 1'b1;
                    used_reg  <= stk_used[dx - 1'b1];
                    w_reg     <= stk_w[dx - 1'b1];
                    m_reg     <= stk_m[dx - 1'b1];
                    trial_reg <= trial_reg & ~(N'(1) << pop_j);
                    j_reg     <= dss_pkg::CNT_W'(pop_j) + 1'b1;
                end else if (!status.fits) begin
                    j_reg <= j_reg + 1'b1;
                end else begin
                    d_reg     <= d_reg + 1'b1;
                    used_reg  <= used_reg | mask_mem[jx];
                    w_reg     <= w_reg + dss_pkg::WSUM_W'(wt_mem[jx]);
                    m_reg     <= m_reg + dss_pkg::MSUM_W'(met_mem[jx]);
                    trial_reg <= trial_reg | (N'(1) << jx);
                    j_reg     <= j_reg + 1'b1;
                end
            end
            if (cmd.visit && beats) begin
                best_reg  <= trial_reg;
                bsize_reg <= d_reg;
                bw_reg    <= w_reg;
                bm_reg    <= m_reg;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                best_reg    <= best_reg & ~(N'(1) << top_idx);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            idx_reg  <= top_idx;
            none_reg <= (best_reg == '0);
            ovf_reg  <= drop_reg;
            last_reg <= status.emit_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item_index    = idx_reg;
    assign m_none_selected = none_reg;
    assign m_overflowed    = ovf_reg;
    assign m_last_result   = last_reg;

    a_depth_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        d_reg <= count_reg)
        else $error("search depth beyond loaded count");

    a_trial_matches_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(trial_reg) == int'(d_reg))
        else $error("trial subset size differs from depth");

    a_root_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_reg == '0) |-> (used_reg == '0 && w_reg == '0 && m_reg == '0))
        else $error("root of search carries resources");

endmodule
`default_nettype wire

FILE: tb/tb_disjoint_subset_selector_core.sv
`timescale 1ns / 1ps
module tb_disjoint_subset_selector_core;
    import dss_pkg::*;

    typedef struct {
        logic              iv;
        logic [MASK_W-1:0] mask;
        logic [WT_W-1:0]   wt;
        logic [MET_W-1:0]  met;
        logic              last;
    } pick_item_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             none;
        logic             ovf;
        logic             last;
    } pick_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic s_item_valid = 0;
    logic [MASK_W-1:0] s_item_mask = '0;
    logic [WT_W-1:0] s_item_weight = '0;
    logic [MET_W-1:0] s_item_metric = '0;
    logic s_last_item = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [IDX_W-1:0] m_item_index;
    logic m_none_selected, m_overflowed, m_last_result;

    disjoint_subset_selector_core dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    pick_item_t   pending_items[$];
    pick_result_t expected_picks[$];

    logic              cfg_weight = 0, cfg_metric = 0;
    logic [MASK_W-1:0] held_mask[MAX_ITEMS];
    logic [WT_W-1:0]   held_wt[MAX_ITEMS];
    logic [MET_W-1:0]  held_met[MAX_ITEMS];
    int                held_cnt = 0;
    logic              held_drop = 0;
    logic [MAX_ITEMS-1:0] top_subset;
    int  top_size, top_wsum, top_msum;

    bit  calm = 0;
    bit  in_taken = 0;
    int  gap_left = 0, stall_left = 0;
    int  errors = 0, idle_cycles = 0;
    int  sets_done = 0, results_seen = 0, overflow_sets = 0, random_items = 0;

    function automatic bit beats_top(int cnt, int ws, int ms);
        if (cnt != top_size) return cnt > top_size;
        if (cfg_weight && ws != top_wsum) return ws > top_wsum;
        if (cfg_metric) return ms < top_msum;
        return 0;
    endfunction

    function automatic void search_packing(int nxt, logic [MASK_W-1:0] used, int cnt,
                                           int ws, int ms, logic [MAX_ITEMS-1:0] trial);
        if (beats_top(cnt, ws, ms)) begin
            top_subset = trial;
            top_size = cnt;
            top_wsum = ws;
            top_msum = ms;
        end
        if (cnt + (held_cnt - nxt) < top_size) return;
        for (int j = nxt; j < held_cnt; j++) begin
            if ((used & held_mask[j]) == 0)
                search_packing(j + 1, used | held_mask[j], cnt + 1, ws + held_wt[j],
                               ms + held_met[j], trial | (MAX_ITEMS'(1) << j));
        end
    endfunction

    task automatic absorb_item(pick_item_t it);
        pick_result_t r;
        if (it.iv) begin
            if (held_cnt < MAX_ITEMS) begin
                held_mask[held_cnt] = it.mask;
                held_wt[held_cnt] = it.wt;
                held_met[held_cnt] = it.met;
                held_cnt++;
            end else held_drop = 1;
        end
        if (!it.last) return;
        top_subset = '0; top_size = 0; top_wsum = 0; top_msum = 0;
        search_packing(0, '0, 0, 0, 0, '0);
        if (top_size == 0) begin
            r = '{idx: '0, none: 1, ovf: held_drop, last: 1};
            expected_picks.insert(expected_picks.size(), r);
        end else begin
            for (int k = MAX_ITEMS - 1; k >= 0; k--) begin
                if (top_subset[k]) begin
                    r = '{idx: IDX_W'(k), none: 0, ovf: held_drop, last: 0};
                    expected_picks.insert(expected_picks.size(), r);
                end
            end
            expected_picks[expected_picks.size() - 1].last = 1;
        end
        sets_done++;
        if (held_drop) overflow_sets++;
        held_cnt = 0;
        held_drop = 0;
    endtask

    always @(posedge aclk) begin
        pick_item_t   it;
        pick_result_t e;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            it = '{s_item_valid, s_item_mask, s_item_weight, s_item_metric, s_last_item};
            absorb_item(it);
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected result idx=%0d none=%0b ovf=%0b last=%0b", $time,
                         m_item_index, m_none_selected, m_overflowed, m_last_result);
                errors++;
            end else begin
                e = expected_picks.pop_front();
                if (m_item_index !== e.idx || m_none_selected !== e.none ||
                    m_overflowed !== e.ovf || m_last_result !== e.last) begin
                    $display("%0t: mismatch expected idx=%0d none=%0b ovf=%0b last=%0b, %s",
                             $time, e.idx, e.none, e.ovf, e.last, "got");
                    $display("%0t:          actual   idx=%0d none=%0b ovf=%0b last=%0b",
                             $time, m_item_index, m_none_selected, m_overflowed,
                             m_last_result);
                    errors++;
                end
            end
        end
        if (in_taken || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= 1000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        pick_item_t it;
        if (!aresetn) s_valid <= 0;
        else if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 8);
                s_valid <= 0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_item_valid <= it.iv;
                s_item_mask <= it.mask;
                s_item_weight <= it.wt;
                s_item_metric <= it.met;
                s_last_item <= it.last;
                s_valid <= 1;
            end else s_valid <= 0;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 0;
        end else m_ready <= 1;
    end

    task automatic apb_write(logic reg_idx, logic value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= PADDR_W'({reg_idx, 2'b00});
        pwdata <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (reg_idx == REG_PREFER_WEIGHT) cfg_weight = value;
        else cfg_metric = value;
    endtask

    task automatic set_prefs(logic w, logic m);
        apb_write(REG_PREFER_WEIGHT, w);
        apb_write(REG_PREFER_METRIC, m);
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || s_valid || expected_picks.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic push_item(logic iv, logic [MASK_W-1:0] mask, logic [WT_W-1:0] wt,
                             logic [MET_W-1:0] met, logic last);
        pick_item_t it;
        it = '{iv, mask, wt, met, last};
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(0, 9))
            0: m = $urandom();
            1: m = '0;
            default: begin
                m = '0;
                repeat ($urandom_range(1, 3)) m[$urandom_range(0, 7)] = 1;
                m = m << ($urandom_range(0, 3) * 8);
            end
        endcase
        return m;
    endfunction

    task automatic random_set(int n, bit with_marker);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) push_item(0, $urandom(), $urandom(), $urandom(), 0);
            push_item(1, pick_mask(), $urandom(), $urandom(),
                      !with_marker && i == n - 1);
            random_items++;
        end
        if (with_marker) push_item(0, $urandom(), $urandom(), $urandom(), 1);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        set_prefs(0, 0);
        // empty set, lone full-mask item, plain conflicts
        push_item(0, '0, '0, '0, 1);
        push_item(1, '1, 4'hF, 16'hFFFF, 1);
        push_item(1, 32'h3, 4'd1, 16'd10, 0);
        push_item(1, 32'h6, 4'd9, 16'd5, 0);
        push_item(1, 32'hC, 4'd2, 16'd1, 1);
        drain();
        set_prefs(1, 1);
        push_item(1, 32'h3, 4'd1, 16'd10, 0);
        push_item(1, 32'h6, 4'd9, 16'd5, 0);
        push_item(1, 32'hC, 4'd2, 16'd1, 0);
        push_item(1, 32'h1, 4'd9, 16'd0, 0);
        push_item(0, '0, '0, '0, 1);
        drain();
        // overflow, the dropped item carries the end flag
        for (int i = 0; i < MAX_ITEMS + 1; i++)
            push_item(1, 32'h1 << (i % 4), 4'(i), 16'(i * 997), i == MAX_ITEMS);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            set_prefs($urandom_range(0, 1), $urandom_range(0, 1));
            if (ph == 7) calm = 1;
            if (ph == 3) random_set(MAX_ITEMS, 0);
            while (random_items < (ph + 1) * 24) begin
                random_set($urandom_range(1, 9), $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 5) == 0) drain();
            end
            drain();
        end
        set_prefs(0, 1);
        random_set(6, 1);
        drain();
        $display("%0d sets searched, %0d results checked, %0d sets with overflow",
                 sets_done, results_seen, overflow_sets);
        $display("all ranking settings exercised including empty and full sets");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
